// ----- rtl/core/psrf_pkg.sv -----
// psrf_pkg: shared types, opcodes, reason codes and constants
// for the packet source rate filter core; no dependencies
package psrf_pkg;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [3:0]  header_words;
    logic [31:0] source_address;
    logic [63:0] timestamp_ns;
    logic [2:0]  counter_select;
  } psrf_in_t;

  typedef struct packed {
    logic        verdict;
    logic [3:0]  reason;
    logic [63:0] counter_value;
  } psrf_out_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic lookup;
    logic read;
    logic commit;
  } psrf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } psrf_sts_t;

  localparam logic [2:0] OP_PACKET       = 3'd0;
  localparam logic [2:0] OP_ALLOW_ADD    = 3'd1;
  localparam logic [2:0] OP_ALLOW_REMOVE = 3'd2;
  localparam logic [2:0] OP_BLOCK_ADD    = 3'd3;
  localparam logic [2:0] OP_BLOCK_REMOVE = 3'd4;
  localparam logic [2:0] OP_READ         = 3'd5;

  localparam logic [3:0] RSN_BYPASS    = 4'd0;
  localparam logic [3:0] RSN_ALLOWED   = 4'd1;
  localparam logic [3:0] RSN_PASSED    = 4'd2;
  localparam logic [3:0] RSN_BLOCKED   = 4'd3;
  localparam logic [3:0] RSN_GLOBAL    = 4'd4;
  localparam logic [3:0] RSN_SOURCE    = 4'd5;
  localparam logic [3:0] RSN_LIST_OK   = 4'd6;
  localparam logic [3:0] RSN_LIST_FULL = 4'd7;
  localparam logic [3:0] RSN_READ      = 4'd8;

  localparam logic [2:0] EV_TOTAL    = 3'd0;
  localparam logic [2:0] EV_ALLOWED  = 3'd1;
  localparam logic [2:0] EV_PASSED   = 3'd2;
  localparam logic [2:0] EV_BLOCKED  = 3'd3;
  localparam logic [2:0] EV_GLOBAL   = 3'd4;
  localparam logic [2:0] EV_SOURCE   = 3'd5;
  localparam int         COUNTER_COUNT = 6;

  localparam logic [1:0] CFG_ENABLE     = 2'd0;
  localparam logic [1:0] CFG_SRC_LIMIT  = 2'd1;
  localparam logic [1:0] CFG_GLB_LIMIT  = 2'd2;
  localparam logic [1:0] CFG_WINDOW_LEN = 2'd3;

  localparam logic        RST_ENABLE     = 1'b1;
  localparam logic [31:0] RST_SRC_LIMIT  = 32'd1000;
  localparam logic [31:0] RST_GLB_LIMIT  = 32'd100000;
  localparam logic [39:0] RST_WINDOW_LEN = 40'd1000000000;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [16:0] ETH_HDR_BYTES  = 17'd14;
  localparam logic [15:0] IP_MIN_FRAME   = 16'd34;
  localparam logic [3:0]  IP_MIN_WORDS   = 4'd5;

  function automatic logic [31:0] sat_inc32(input logic [31:0] v);
    sat_inc32 = (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic logic [63:0] sat_inc64(input logic [63:0] v);
    sat_inc64 = (v == '1) ? v : v + 64'd1;
  endfunction

endpackage

// ----- rtl/core/psrf_list.sv -----
// psrf_list: key list with valid bits and parallel match
// depends on psrf_pkg
module psrf_list import psrf_pkg::*; #(
  parameter int N = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] key,
  input  logic        lookup,
  input  logic        add_en,
  input  logic        remove_en,
  output logic        hit_r,
  output logic        full_r
);

  localparam int IW = (N > 1) ? $clog2(N) : 1;

  logic [31:0]   keys_r [N];
  logic [N-1:0]  valid_r;
  logic [N-1:0]  match;
  logic [IW-1:0] hit_idx, free_idx;
  logic [IW-1:0] hit_idx_r, free_idx_r;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = valid_r[i] && (keys_r[i] == key);
    end
    // lowest index wins
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = IW'(i);
      if (!valid_r[i]) free_idx = IW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
      full_r  <= 1'b0;
    end else begin
      if (lookup) begin
        hit_r  <= |match;
        full_r <= &valid_r;
      end
      if (add_en && !hit_r && !full_r) valid_r[free_idx_r] <= 1'b1;
      if (remove_en && hit_r) valid_r[hit_idx_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup) begin
      hit_idx_r  <= hit_idx;
      free_idx_r <= free_idx;
    end
    if (add_en && !hit_r && !full_r) keys_r[free_idx_r] <= key;
  end

endmodule

// ----- rtl/core/psrf_track.sv -----
// psrf_track: per-source window table with lru replacement
// keys and ages in cells, window start and count in a memory; depends on psrf_pkg
module psrf_track import psrf_pkg::*; #(
  parameter int N = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] key,
  input  logic [63:0] now,
  input  logic [39:0] window_length,
  input  logic [31:0] per_source_limit,
  input  logic        lookup,
  input  logic        read,
  input  logic        update,
  output logic        src_drop
);

  localparam int IW = $clog2(N);

  typedef struct packed {
    logic [63:0] start;
    logic [31:0] count;
  } entry_t;

  logic [31:0]   keys_r [N];
  logic [IW-1:0] age_r  [N];
  logic [N-1:0]  valid_r;
  entry_t        mem [N];
  entry_t        rd_r, wr_data;

  logic [N-1:0]  match;
  logic [IW-1:0] hit_idx, free_idx, old_idx;
  logic [IW-1:0] hit_idx_r, ins_idx_r, target;
  logic          hit_r, full_r;
  logic          same;
  logic [31:0]   cnt_inc;
  logic [IW-1:0] target_age;
  logic          grow_all;

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    old_idx  = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = valid_r[i] && (keys_r[i] == key);
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = IW'(i);
      if (!valid_r[i]) free_idx = IW'(i);
      if (age_r[i] == IW'(N - 1)) old_idx = IW'(i);
    end
  end

  always_comb begin
    same     = hit_r && ((now - rd_r.start) < {24'd0, window_length});
    cnt_inc  = sat_inc32(rd_r.count);
    src_drop = same && (cnt_inc > per_source_limit);
    target   = hit_r ? hit_idx_r : ins_idx_r;
    // a full table evicts the entry whose age is the largest
    target_age = hit_r ? age_r[hit_idx_r] : IW'(N - 1);
    grow_all   = !hit_r && !full_r;
    wr_data.start = same ? rd_r.start : now;
    wr_data.count = same ? cnt_inc : 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
      full_r  <= 1'b0;
      for (int j = 0; j < N; j++) age_r[j] <= '0;
    end else begin
      if (lookup) begin
        hit_r  <= |match;
        full_r <= &valid_r;
      end
      if (update) begin
        for (int j = 0; j < N; j++) begin
          if (valid_r[j] && (IW'(j) != target) && (grow_all || age_r[j] < target_age))
            age_r[j] <= age_r[j] + 1'b1;
        end
        age_r[target]   <= '0;
        valid_r[target] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup) begin
      hit_idx_r <= hit_idx;
      ins_idx_r <= (&valid_r) ? old_idx : free_idx;
    end
    if (update && !hit_r) keys_r[target] <= key;
  end

  always_ff @(posedge clk) begin
    if (read) rd_r <= mem[hit_idx_r];
    if (update) mem[target] <= wr_data;
  end

endmodule

// ----- rtl/core/psrf_datapath.sv -----
// psrf_datapath: item register, config, global window, event counters,
// decision logic and result register; depends on psrf_pkg, psrf_list, psrf_track
module psrf_datapath import psrf_pkg::*; #(
  parameter int ALLOW_ENTRIES = 32,
  parameter int BLOCK_ENTRIES = 32,
  parameter int TRACK_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  psrf_cmd_t   cmd,
  output psrf_sts_t   sts,
  input  psrf_in_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output psrf_out_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data
);

  psrf_in_t    item_r;
  psrf_out_t   out_item_r, res;
  logic        out_valid_r;

  logic        enable_r;
  logic [31:0] src_limit_r, glb_limit_r;
  logic [39:0] window_r;

  logic [63:0] gstart_r;
  logic [31:0] gcount_r, g_inc;
  logic        g_same_r;
  logic [63:0] ev_r [COUNTER_COUNT];

  logic allow_hit, allow_full, block_hit, block_full;
  logic src_drop;
  logic is_pkt, wf, filt, g_drop, past_lists, track_upd, passed;
  logic [16:0] hdr_end;

  psrf_list #(.N(ALLOW_ENTRIES)) u_allow (
    .clk       (clk),
    .rst_n     (rst_n),
    .key       (item_r.source_address),
    .lookup    (cmd.lookup),
    .add_en    (cmd.commit && item_r.opcode == OP_ALLOW_ADD),
    .remove_en (cmd.commit && item_r.opcode == OP_ALLOW_REMOVE),
    .hit_r     (allow_hit),
    .full_r    (allow_full)
  );

  psrf_list #(.N(BLOCK_ENTRIES)) u_block (
    .clk       (clk),
    .rst_n     (rst_n),
    .key       (item_r.source_address),
    .lookup    (cmd.lookup),
    .add_en    (cmd.commit && item_r.opcode == OP_BLOCK_ADD),
    .remove_en (cmd.commit && item_r.opcode == OP_BLOCK_REMOVE),
    .hit_r     (block_hit),
    .full_r    (block_full)
  );

  psrf_track #(.N(TRACK_ENTRIES)) u_track (
    .clk              (clk),
    .rst_n            (rst_n),
    .key              (item_r.source_address),
    .now              (item_r.timestamp_ns),
    .window_length    (window_r),
    .per_source_limit (src_limit_r),
    .lookup           (cmd.lookup),
    .read             (cmd.read),
    .update           (track_upd),
    .src_drop         (src_drop)
  );

  always_comb begin
    is_pkt  = item_r.opcode == OP_PACKET;
    hdr_end = ETH_HDR_BYTES + {11'd0, item_r.header_words, 2'b00};
    wf = (item_r.ether_type == ETHERTYPE_IPV4) && (item_r.frame_length >= IP_MIN_FRAME) &&
         (item_r.header_words >= IP_MIN_WORDS) && (hdr_end <= {1'b0, item_r.frame_length});
    filt       = enable_r && wf;
    g_inc      = sat_inc32(gcount_r);
    g_drop     = g_same_r && (g_inc > glb_limit_r);
    past_lists = is_pkt && filt && !allow_hit && !block_hit;
    track_upd  = cmd.commit && past_lists && !g_drop;
    passed     = past_lists && !g_drop && !src_drop;

    res = '0;
    case (item_r.opcode)
      OP_PACKET: begin
        if (!filt) res.reason = RSN_BYPASS;
        else if (allow_hit) res.reason = RSN_ALLOWED;
        else if (block_hit) begin
          res.verdict = 1'b1;
          res.reason  = RSN_BLOCKED;
        end else if (g_drop) begin
          res.verdict = 1'b1;
          res.reason  = RSN_GLOBAL;
        end else if (src_drop) begin
          res.verdict = 1'b1;
          res.reason  = RSN_SOURCE;
        end else res.reason = RSN_PASSED;
      end
      OP_ALLOW_ADD:
        res.reason = (allow_full && !allow_hit) ? RSN_LIST_FULL : RSN_LIST_OK;
      OP_BLOCK_ADD:
        res.reason = (block_full && !block_hit) ? RSN_LIST_FULL : RSN_LIST_OK;
      OP_ALLOW_REMOVE, OP_BLOCK_REMOVE: res.reason = RSN_LIST_OK;
      OP_READ: begin
        res.reason = RSN_READ;
        case (item_r.counter_select)
          EV_TOTAL:   res.counter_value = ev_r[0];
          EV_ALLOWED: res.counter_value = ev_r[1];
          EV_PASSED:  res.counter_value = ev_r[2];
          EV_BLOCKED: res.counter_value = ev_r[3];
          EV_GLOBAL:  res.counter_value = ev_r[4];
          EV_SOURCE:  res.counter_value = ev_r[5];
          default:    res.counter_value = '0;
        endcase
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) item_r <= in_item;
    if (cmd.commit) out_item_r <= res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      enable_r    <= RST_ENABLE;
      src_limit_r <= RST_SRC_LIMIT;
      glb_limit_r <= RST_GLB_LIMIT;
      window_r    <= RST_WINDOW_LEN;
      gstart_r    <= '0;
      gcount_r    <= '0;
      g_same_r    <= 1'b0;
      for (int k = 0; k < COUNTER_COUNT; k++) ev_r[k] <= '0;
    end else begin
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENABLE:     enable_r    <= cfg_data[0];
          CFG_SRC_LIMIT:  src_limit_r <= cfg_data[31:0];
          CFG_GLB_LIMIT:  glb_limit_r <= cfg_data[31:0];
          CFG_WINDOW_LEN: window_r    <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.lookup)
        g_same_r <= (item_r.timestamp_ns - gstart_r) < {24'd0, window_r};

      if (cmd.commit && past_lists) begin
        if (g_same_r) gcount_r <= g_inc;
        else begin
          gstart_r <= item_r.timestamp_ns;
          gcount_r <= 32'd1;
        end
      end

      if (cmd.commit && is_pkt) begin
        ev_r[0] <= sat_inc64(ev_r[0]);
        if (filt && allow_hit) ev_r[1] <= sat_inc64(ev_r[1]);
        if (filt && (allow_hit || passed)) ev_r[2] <= sat_inc64(ev_r[2]);
        if (filt && !allow_hit && block_hit) ev_r[3] <= sat_inc64(ev_r[3]);
        if (past_lists && g_drop) ev_r[4] <= sat_inc64(ev_r[4]);
        if (past_lists && !g_drop && src_drop) ev_r[5] <= sat_inc64(ev_r[5]);
      end
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;

endmodule

// ----- rtl/core/psrf_ctrl.sv -----
// psrf_ctrl: sequencing state machine for one item at a time
// depends on psrf_pkg
module psrf_ctrl import psrf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  psrf_sts_t sts,
  output psrf_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_MATCH, S_READ, S_EXEC} state_t;

  state_t state_r;
  logic   in_ready_r;

  always_comb begin
    cmd.latch  = (state_r == S_IDLE) && in_valid;
    cmd.lookup = state_r == S_MATCH;
    cmd.read   = state_r == S_READ;
    cmd.commit = (state_r == S_EXEC) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_valid) begin
          state_r    <= S_MATCH;
          in_ready_r <= 1'b0;
        end
        S_MATCH: state_r <= S_READ;
        S_READ:  state_r <= S_EXEC;
        // wait here while the result register is still occupied
        S_EXEC: if (sts.out_free) begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready = in_ready_r;

endmodule

// ----- rtl/core/packet_source_rate_filter_core.sv -----
// packet_source_rate_filter_core: top level, controller plus datapath
// sequence: after the input transfer the item passes the match, table read and execute states,
// and the result is registered in execute; a new item is taken only once execute is left,
// and execute is held while the result register is held by out_ready low
// reset: synchronous active-low rst_n clears lists, table, windows, counters, config defaults
module packet_source_rate_filter_core import psrf_pkg::*; #(
  parameter int ALLOW_ENTRIES = 32,
  parameter int BLOCK_ENTRIES = 32,
  parameter int TRACK_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  psrf_in_t    in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output psrf_out_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data
);

  psrf_cmd_t cmd;
  psrf_sts_t sts;

  psrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  psrf_datapath #(
    .ALLOW_ENTRIES (ALLOW_ENTRIES),
    .BLOCK_ENTRIES (BLOCK_ENTRIES),
    .TRACK_ENTRIES (TRACK_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
